@@ hdl/shbt_pkg.sv @@
// Shared types and constants for the swept box hit test.
// Used by the interfaces, the datapath units and the top level; no dependencies.
package shbt_pkg;

	localparam int CW       = 32;
	localparam int SZ_W     = CW - 1;
	localparam int GAP_W    = CW + 2;
	localparam int SQ_W     = 2 * CW;
	localparam int ROOT_W   = CW;
	localparam int REM_W    = ROOT_W + 2;
	localparam int QUO_W    = CW - 1;
	localparam int DIV_LAT  = QUO_W + 1;
	localparam int SQRT_LAT = ROOT_W;
	localparam int AT_W     = CW + 4;

	typedef enum logic [1:0] {
		FACE_XNEG = 2'd0,
		FACE_XPOS = 2'd1,
		FACE_YNEG = 2'd2,
		FACE_YPOS = 2'd3
	} face_t;

	typedef struct packed {
		logic signed [CW-1:0] mover_x;
		logic signed [CW-1:0] mover_y;
		logic [SZ_W-1:0]      mover_width;
		logic [SZ_W-1:0]      mover_height;
		logic signed [CW-1:0] dir_x;
		logic signed [CW-1:0] dir_y;
		logic [SZ_W-1:0]      step_limit;
		logic signed [CW-1:0] target_x;
		logic signed [CW-1:0] target_y;
		logic [SZ_W-1:0]      target_width;
		logic [SZ_W-1:0]      target_height;
		logic                 target_enabled;
	} item_t;

	typedef struct packed {
		logic            hit_found;
		logic [SZ_W-1:0] hit_distance;
		logic [1:0]      hit_face;
	} result_t;

	// one face candidate as handed to a face lane
	typedef struct packed {
		logic                 act;
		face_t                face;
		logic [SZ_W-1:0]      gap;
		logic [CW-1:0]        main_abs;
		logic signed [CW-1:0] other;
		logic [SZ_W-1:0]      step;
		logic signed [CW-1:0] pos;
		logic [SZ_W-1:0]      size;
		logic signed [CW-1:0] tpos;
		logic [SZ_W-1:0]      tsize;
	} face_in_t;

	typedef struct packed {
		logic            hit;
		face_t           face;
		logic [SZ_W-1:0] span;
	} face_res_t;

endpackage

@@ hdl/shbt_if.sv @@
// Valid/ready channels for input items and result words.
// Depends on shbt_pkg for the payload types.
interface shbt_item_if;
	logic            valid;
	logic            ready;
	shbt_pkg::item_t data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface shbt_result_if;
	logic              valid;
	logic              ready;
	shbt_pkg::result_t data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ hdl/shbt_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on shbt_pkg for widths.
module shbt_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [shbt_pkg::SQ_W-1:0]   radicand,
	output logic                        out_valid,
	output logic [shbt_pkg::ROOT_W-1:0] root
);

	logic                        v_s   [0:shbt_pkg::SQRT_LAT-1];
	logic [shbt_pkg::REM_W-1:0]  rem_s [0:shbt_pkg::SQRT_LAT-1];
	logic [shbt_pkg::ROOT_W-1:0] rt_s  [0:shbt_pkg::SQRT_LAT-1];
	logic [shbt_pkg::SQ_W-1:0]   nb_s  [0:shbt_pkg::SQRT_LAT-1];

	for (genvar k = 0; k < shbt_pkg::SQRT_LAT; k++) begin : g_stage
		logic                         v_i;
		logic [shbt_pkg::REM_W-1:0]   rem_i;
		logic [shbt_pkg::ROOT_W-1:0]  rt_i;
		logic [shbt_pkg::SQ_W-1:0]    nb_i;
		logic [shbt_pkg::REM_W+1:0]   cur;
		logic [shbt_pkg::REM_W+1:0]   trial;
		logic                         ge;

		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign rem_i = '0;
			assign rt_i  = '0;
			assign nb_i  = radicand;
		end else begin : g_next
			assign v_i   = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign rt_i  = rt_s[k-1];
			assign nb_i  = nb_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_i, nb_i[shbt_pkg::SQ_W-1 -: 2]};
		assign trial = {(shbt_pkg::REM_W)'(rt_i), 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (shbt_pkg::REM_W)'(cur - trial) : cur[shbt_pkg::REM_W-1:0];
				rt_s[k]  <= {rt_i[shbt_pkg::ROOT_W-2:0], ge};
				nb_s[k]  <= {nb_i[shbt_pkg::SQ_W-3:0], 2'b00};
			end
		end
	end

	assign out_valid = v_s[shbt_pkg::SQRT_LAT-1];
	assign root      = rt_s[shbt_pkg::SQRT_LAT-1];

endmodule

@@ hdl/shbt_div.sv @@
// Pipelined restoring divider: wide dividend over CW-bit divisor, one quotient
// bit per stage, flags a quotient that does not fit. Depends on shbt_pkg.
module shbt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [shbt_pkg::SQ_W-1:0]  num,
	input  logic [shbt_pkg::CW-1:0]    den,
	output logic                       out_valid,
	output logic [shbt_pkg::QUO_W-1:0] quo,
	output logic                       ovf,
	output logic                       rem_nz
);

	logic                       v_s   [0:shbt_pkg::DIV_LAT-1];
	logic [shbt_pkg::CW-1:0]    rem_s [0:shbt_pkg::DIV_LAT-1];
	logic [shbt_pkg::QUO_W-1:0] low_s [0:shbt_pkg::DIV_LAT-1];
	logic [shbt_pkg::QUO_W-1:0] quo_s [0:shbt_pkg::DIV_LAT-1];
	logic [shbt_pkg::CW-1:0]    den_s [0:shbt_pkg::DIV_LAT-1];
	logic                       ovf_s [0:shbt_pkg::DIV_LAT-1];

	logic [shbt_pkg::CW:0] num_hi;

	assign num_hi = num[shbt_pkg::SQ_W-1:shbt_pkg::QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// top part already at or above the divisor: quotient needs more than QUO_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_hi[shbt_pkg::CW-1:0];
			low_s[0] <= num[shbt_pkg::QUO_W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= num_hi >= (shbt_pkg::CW+1)'(den);
		end
	end

	for (genvar k = 1; k < shbt_pkg::DIV_LAT; k++) begin : g_stage
		logic [shbt_pkg::CW:0] trial;
		logic [shbt_pkg::CW:0] den_e;
		logic                  ge;

		assign trial = {rem_s[k-1], low_s[k-1][shbt_pkg::QUO_W-1]};
		assign den_e = (shbt_pkg::CW+1)'(den_s[k-1]);
		assign ge    = trial >= den_e;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (shbt_pkg::CW)'(trial - den_e) : trial[shbt_pkg::CW-1:0];
				low_s[k] <= {low_s[k-1][shbt_pkg::QUO_W-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][shbt_pkg::QUO_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign out_valid = v_s[shbt_pkg::DIV_LAT-1];
	assign quo       = quo_s[shbt_pkg::DIV_LAT-1];
	assign ovf       = ovf_s[shbt_pkg::DIV_LAT-1];
	assign rem_nz    = rem_s[shbt_pkg::DIV_LAT-1] != '0;

endmodule

@@ hdl/shbt_face.sv @@
// One face lane: contact distance, other-axis position at contact, overlap test.
// Depends on shbt_pkg and shbt_div.
module shbt_face (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  shbt_pkg::face_in_t          fin,
	input  logic [shbt_pkg::ROOT_W-1:0] len,
	output logic                        out_valid,
	output shbt_pkg::face_res_t         fres
);

	typedef struct packed {
		logic                           act;
		shbt_pkg::face_t                face;
		logic [shbt_pkg::SZ_W-1:0]      step;
		logic signed [shbt_pkg::CW-1:0] other;
		logic signed [shbt_pkg::CW-1:0] pos;
		logic [shbt_pkg::SZ_W-1:0]      size;
		logic signed [shbt_pkg::CW-1:0] tpos;
		logic [shbt_pkg::SZ_W-1:0]      tsize;
		logic [shbt_pkg::ROOT_W-1:0]    len;
	} side_a_t;

	typedef struct packed {
		logic                           ok;
		logic                           neg;
		logic [shbt_pkg::SZ_W-1:0]      d;
		shbt_pkg::face_t                face;
		logic signed [shbt_pkg::CW-1:0] pos;
		logic [shbt_pkg::SZ_W-1:0]      size;
		logic signed [shbt_pkg::CW-1:0] tpos;
		logic [shbt_pkg::SZ_W-1:0]      tsize;
	} side_b_t;

	// stage 1: gap * len
	logic                      v_s1;
	logic [shbt_pkg::SQ_W-1:0] prod_s1;
	logic [shbt_pkg::CW-1:0]   main_s1;
	side_a_t                   side_s1;
	side_a_t                   side_a_s [0:shbt_pkg::DIV_LAT-1];

	logic                       va_o;
	logic [shbt_pkg::QUO_W-1:0] quo_a;
	logic                       ovf_a;
	logic                       rnz_a;

	// stage 2: distance check, distance * |other|
	side_a_t                   sa;
	logic                      ok_n;
	logic [shbt_pkg::CW-1:0]   abs_o;
	logic                      v_s2;
	logic [shbt_pkg::SQ_W-1:0] prod_s2;
	logic [shbt_pkg::CW-1:0]   len_s2;
	side_b_t                   side_s2;
	side_b_t                   side_b_s [0:shbt_pkg::DIV_LAT-1];

	logic                       vb_o;
	logic [shbt_pkg::QUO_W-1:0] quo_b;
	logic                       ovf_b;
	logic                       rnz_b;

	// stage 3: other-axis position at contact
	side_b_t                          sb;
	side_b_t                          sb_n;
	logic [shbt_pkg::CW-1:0]          mag;
	logic signed [shbt_pkg::AT_W-1:0] mag_e;
	logic signed [shbt_pkg::AT_W-1:0] off;
	logic                             v_s3;
	logic signed [shbt_pkg::AT_W-1:0] at_s3;
	side_b_t                          side_s3;

	// stage 4: overlap with touching counted
	logic signed [shbt_pkg::AT_W-1:0] lo;
	logic signed [shbt_pkg::AT_W-1:0] tp;
	logic signed [shbt_pkg::AT_W-1:0] hi;
	logic                             miss;
	logic                             v_s4;
	shbt_pkg::face_res_t              res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= va_o;
			v_s3 <= vb_o;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1       <= (shbt_pkg::SQ_W)'(fin.gap) * (shbt_pkg::SQ_W)'(len);
			main_s1       <= fin.main_abs;
			side_s1.act   <= fin.act;
			side_s1.face  <= fin.face;
			side_s1.step  <= fin.step;
			side_s1.other <= fin.other;
			side_s1.pos   <= fin.pos;
			side_s1.size  <= fin.size;
			side_s1.tpos  <= fin.tpos;
			side_s1.tsize <= fin.tsize;
			side_s1.len   <= len;
			side_a_s[0]   <= side_s1;
			for (int i = 1; i < shbt_pkg::DIV_LAT; i++) begin
				side_a_s[i] <= side_a_s[i-1];
			end
		end
	end

	shbt_div u_div_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       (prod_s1),
		.den       (main_s1),
		.out_valid (va_o),
		.quo       (quo_a),
		.ovf       (ovf_a),
		.rem_nz    (rnz_a)
	);

	assign sa    = side_a_s[shbt_pkg::DIV_LAT-1];
	assign ok_n  = sa.act && !ovf_a && (quo_a < sa.step);
	assign abs_o = sa.other[shbt_pkg::CW-1] ? (~sa.other + 1'b1) : sa.other;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2       <= (shbt_pkg::SQ_W)'(quo_a) * (shbt_pkg::SQ_W)'(abs_o);
			len_s2        <= sa.len;
			side_s2.ok    <= ok_n;
			side_s2.neg   <= sa.other[shbt_pkg::CW-1];
			side_s2.d     <= quo_a;
			side_s2.face  <= sa.face;
			side_s2.pos   <= sa.pos;
			side_s2.size  <= sa.size;
			side_s2.tpos  <= sa.tpos;
			side_s2.tsize <= sa.tsize;
			side_b_s[0]   <= side_s2;
			for (int i = 1; i < shbt_pkg::DIV_LAT; i++) begin
				side_b_s[i] <= side_b_s[i-1];
			end
		end
	end

	shbt_div u_div_offs (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (prod_s2),
		.den       (len_s2),
		.out_valid (vb_o),
		.quo       (quo_b),
		.ovf       (ovf_b),
		.rem_nz    (rnz_b)
	);

	// negative offsets round toward minus infinity: bump magnitude on a remainder
	assign sb    = side_b_s[shbt_pkg::DIV_LAT-1];
	assign mag   = (shbt_pkg::CW)'(quo_b) + (shbt_pkg::CW)'(sb.neg & rnz_b);
	assign mag_e = $signed((shbt_pkg::AT_W)'(mag));
	assign off   = sb.neg ? -mag_e : mag_e;

	// quotient never overflows when the distance is in range
	always_comb begin
		sb_n    = sb;
		sb_n.ok = sb.ok && !ovf_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_s3   <= (shbt_pkg::AT_W)'(sb.pos) + off;
			side_s3 <= sb_n;
		end
	end

	assign lo   = at_s3 + $signed((shbt_pkg::AT_W)'(side_s3.size));
	assign tp   = (shbt_pkg::AT_W)'(side_s3.tpos);
	assign hi   = tp + $signed((shbt_pkg::AT_W)'(side_s3.tsize));
	assign miss = (lo < tp) || (at_s3 > hi);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.hit  <= side_s3.ok && !miss;
			res_s4.face <= side_s3.face;
			res_s4.span <= side_s3.d;
		end
	end

	assign out_valid = v_s4;
	assign fres      = res_s4;

endmodule

@@ hdl/swept_box_hit_test_unit.sv @@
// Swept box hit test: each accepted item gives one result word at the output;
// one item accepted per cycle while the output buffer is not full, set by the fully pipelined
// square root and the two bit-per-stage dividers in each face lane.
// A two-word output buffer lets the pipeline run while a result waits; the
// whole pipeline holds only when that buffer is full.
// Reset clears all valid bits and the buffer count; payload registers are not reset.
module swept_box_hit_test_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	shbt_item_if.sink            item,
	shbt_result_if.source        result
);

	logic en;

	// stage 1: magnitudes and gaps
	logic                              v_s1;
	shbt_pkg::item_t                   itm_s1;
	logic [shbt_pkg::CW-1:0]           adx_s1;
	logic [shbt_pkg::CW-1:0]           ady_s1;
	logic signed [shbt_pkg::GAP_W-1:0] gx_s1;
	logic signed [shbt_pkg::GAP_W-1:0] gy_s1;
	logic signed [shbt_pkg::GAP_W-1:0] gx_n;
	logic signed [shbt_pkg::GAP_W-1:0] gy_n;

	// stage 2: squares, face candidates
	logic                      v_s2;
	logic [shbt_pkg::SQ_W-1:0] sqx_s2;
	logic [shbt_pkg::SQ_W-1:0] sqy_s2;
	shbt_pkg::face_in_t        fx_n;
	shbt_pkg::face_in_t        fy_n;
	shbt_pkg::face_in_t        fx_s2;
	shbt_pkg::face_in_t        fy_s2;

	// stage 3: sum of squares
	logic                      v_s3;
	logic [shbt_pkg::SQ_W-1:0] sum_s3;
	shbt_pkg::face_in_t        fx_s3;
	shbt_pkg::face_in_t        fy_s3;

	shbt_pkg::face_in_t fx_sq_s [0:shbt_pkg::SQRT_LAT-1];
	shbt_pkg::face_in_t fy_sq_s [0:shbt_pkg::SQRT_LAT-1];

	logic                        sq_v;
	logic [shbt_pkg::ROOT_W-1:0] len;

	logic                fx_v;
	logic                fy_v;
	shbt_pkg::face_res_t rx;
	shbt_pkg::face_res_t ry;

	logic              use_x;
	shbt_pkg::result_t res_n;

	shbt_pkg::result_t buf_q [0:1];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic              pop;

	assign en         = (cnt_q != 2'd2);
	assign item.ready = en;

	assign gx_n = item.data.dir_x[shbt_pkg::CW-1]
		? ((shbt_pkg::GAP_W)'(item.data.mover_x) - (shbt_pkg::GAP_W)'(item.data.target_x)
			- $signed((shbt_pkg::GAP_W)'(item.data.target_width)))
		: ((shbt_pkg::GAP_W)'(item.data.target_x) - (shbt_pkg::GAP_W)'(item.data.mover_x)
			- $signed((shbt_pkg::GAP_W)'(item.data.mover_width)));
	assign gy_n = item.data.dir_y[shbt_pkg::CW-1]
		? ((shbt_pkg::GAP_W)'(item.data.mover_y) - (shbt_pkg::GAP_W)'(item.data.target_y)
			- $signed((shbt_pkg::GAP_W)'(item.data.target_height)))
		: ((shbt_pkg::GAP_W)'(item.data.target_y) - (shbt_pkg::GAP_W)'(item.data.mover_y)
			- $signed((shbt_pkg::GAP_W)'(item.data.mover_height)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1 <= item.data;
			adx_s1 <= item.data.dir_x[shbt_pkg::CW-1] ? (~item.data.dir_x + 1'b1) : item.data.dir_x;
			ady_s1 <= item.data.dir_y[shbt_pkg::CW-1] ? (~item.data.dir_y + 1'b1) : item.data.dir_y;
			gx_s1  <= gx_n;
			gy_s1  <= gy_n;
		end
	end

	// a face takes part only when approached from strictly outside and nearer than the step
	always_comb begin
		fx_n.act      = itm_s1.target_enabled && (itm_s1.dir_x != '0) && (gx_s1 > 0)
			&& (gx_s1 < $signed((shbt_pkg::GAP_W)'(itm_s1.step_limit)));
		fx_n.face     = itm_s1.dir_x[shbt_pkg::CW-1] ? shbt_pkg::FACE_XPOS : shbt_pkg::FACE_XNEG;
		fx_n.gap      = gx_s1[shbt_pkg::SZ_W-1:0];
		fx_n.main_abs = adx_s1;
		fx_n.other    = itm_s1.dir_y;
		fx_n.step     = itm_s1.step_limit;
		fx_n.pos      = itm_s1.mover_y;
		fx_n.size     = itm_s1.mover_height;
		fx_n.tpos     = itm_s1.target_y;
		fx_n.tsize    = itm_s1.target_height;

		fy_n.act      = itm_s1.target_enabled && (itm_s1.dir_y != '0) && (gy_s1 > 0)
			&& (gy_s1 < $signed((shbt_pkg::GAP_W)'(itm_s1.step_limit)));
		fy_n.face     = itm_s1.dir_y[shbt_pkg::CW-1] ? shbt_pkg::FACE_YPOS : shbt_pkg::FACE_YNEG;
		fy_n.gap      = gy_s1[shbt_pkg::SZ_W-1:0];
		fy_n.main_abs = ady_s1;
		fy_n.other    = itm_s1.dir_x;
		fy_n.step     = itm_s1.step_limit;
		fy_n.pos      = itm_s1.mover_x;
		fy_n.size     = itm_s1.mover_width;
		fy_n.tpos     = itm_s1.target_x;
		fy_n.tsize    = itm_s1.target_width;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= (shbt_pkg::SQ_W)'(adx_s1) * (shbt_pkg::SQ_W)'(adx_s1);
			sqy_s2 <= (shbt_pkg::SQ_W)'(ady_s1) * (shbt_pkg::SQ_W)'(ady_s1);
			fx_s2  <= fx_n;
			fy_s2  <= fy_n;
			sum_s3 <= sqx_s2 + sqy_s2;
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
			fx_sq_s[0] <= fx_s3;
			fy_sq_s[0] <= fy_s3;
			for (int i = 1; i < shbt_pkg::SQRT_LAT; i++) begin
				fx_sq_s[i] <= fx_sq_s[i-1];
				fy_sq_s[i] <= fy_sq_s[i-1];
			end
		end
	end

	shbt_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.out_valid (sq_v),
		.root      (len)
	);

	shbt_face u_face_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.fin       (fx_sq_s[shbt_pkg::SQRT_LAT-1]),
		.len       (len),
		.out_valid (fx_v),
		.fres      (rx)
	);

	shbt_face u_face_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.fin       (fy_sq_s[shbt_pkg::SQRT_LAT-1]),
		.len       (len),
		.out_valid (fy_v),
		.fres      (ry)
	);

	// x faces come first in the order, so they win ties
	assign use_x = rx.hit && (!ry.hit || (rx.span <= ry.span));

	always_comb begin
		res_n.hit_found    = rx.hit || ry.hit;
		res_n.hit_distance = '0;
		res_n.hit_face     = shbt_pkg::FACE_XNEG;
		if (use_x) begin
			res_n.hit_distance = rx.span;
			res_n.hit_face     = rx.face;
		end else if (ry.hit) begin
			res_n.hit_distance = ry.span;
			res_n.hit_face     = ry.face;
		end
	end

	assign push = en && fx_v;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= res_n;
		end
	end

	assign result.valid = (cnt_q != 2'd0);
	assign result.data  = buf_q[rp_q];

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		fx_v == fy_v)
		else $error("face lanes out of step");

	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> result.valid)
		else $error("input stalled with no word offered");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.hit_found |-> result.data.hit_distance != '0)
		else $error("hit with zero distance");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.hit_found |->
			result.data.hit_distance == '0 && result.data.hit_face == shbt_pkg::FACE_XNEG)
		else $error("miss word carries nonzero fields");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2 && !$past(push))
		else $error("output buffer overfilled");

endmodule

@@ verif/swept_box_hit_test_unit_chk.sv @@
`timescale 1ns / 100ps
// Checker for the swept box hit test: watches the item and result channels,
// predicts each result word from the accepted item and compares field by field.
// Depends on shbt_pkg and the channel interfaces in shbt_if.sv.
module swept_box_hit_test_unit_chk (
	input  logic    clk,
	input  logic    arst_n,
	shbt_item_if    item,
	shbt_result_if  result,
	output int      fail_count,
	output int      pending_hits,
	output int      checked_words
);

	shbt_pkg::result_t expected_hits[$];

	// floor(a * b / len), rounded toward minus infinity
	function automatic longint offset_at(longint unsigned a, longint b, longint unsigned len);
		longint unsigned mag;
		longint unsigned prod;
		mag = (b < 0) ? longint'(-b) : longint'(b);
		prod = a * mag;
		if (b >= 0)
			return longint'(prod / len);
		return -longint'((prod + len - 1) / len);
	endfunction

	function automatic bit face_contact(longint gap, longint unsigned main_abs, longint other_dir,
			longint unsigned len, longint step, longint pos, longint size,
			longint tpos, longint tsize, output longint span);
		longint unsigned d;
		longint at;
		span = 0;
		if (gap <= 0 || gap >= step)
			return 0;
		d = (longint'(gap) * len) / main_abs;
		if (longint'(d) >= step)
			return 0;
		at = pos + offset_at(d, other_dir, len);
		if (at + size < tpos || at > tpos + tsize)
			return 0;
		span = longint'(d);
		return 1;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic shbt_pkg::result_t predict_hit(shbt_pkg::item_t it);
		longint px, py, pw, ph, dx, dy, step, tx, ty, tw, th, best, d;
		longint unsigned adx, ady, len;
		bit found;
		shbt_pkg::face_t face;
		shbt_pkg::result_t r;
		px = $signed(it.mover_x);
		py = $signed(it.mover_y);
		pw = longint'(it.mover_width);
		ph = longint'(it.mover_height);
		dx = $signed(it.dir_x);
		dy = $signed(it.dir_y);
		step = longint'(it.step_limit);
		tx = $signed(it.target_x);
		ty = $signed(it.target_y);
		tw = longint'(it.target_width);
		th = longint'(it.target_height);
		adx = (dx < 0) ? longint'(-dx) : longint'(dx);
		ady = (dy < 0) ? longint'(-dy) : longint'(dy);
		found = 0;
		best = 0;
		face = shbt_pkg::FACE_XNEG;
		if (it.target_enabled && (dx != 0 || dy != 0)) begin
			len = root_floor(adx * adx + ady * ady);
			// later faces win only when strictly nearer
			if (dx > 0 && face_contact(tx - px - pw, adx, dy, len, step, py, ph, ty, th, d)) begin
				found = 1; best = d; face = shbt_pkg::FACE_XNEG;
			end
			if (dx < 0 && face_contact(px - tx - tw, adx, dy, len, step, py, ph, ty, th, d))
				if (!found || d < best) begin
					found = 1; best = d; face = shbt_pkg::FACE_XPOS;
				end
			if (dy > 0 && face_contact(ty - py - ph, ady, dx, len, step, px, pw, tx, tw, d))
				if (!found || d < best) begin
					found = 1; best = d; face = shbt_pkg::FACE_YNEG;
				end
			if (dy < 0 && face_contact(py - ty - th, ady, dx, len, step, px, pw, tx, tw, d))
				if (!found || d < best) begin
					found = 1; best = d; face = shbt_pkg::FACE_YPOS;
				end
		end
		r.hit_found = found;
		r.hit_distance = found ? best[shbt_pkg::SZ_W-1:0] : '0;
		r.hit_face = found ? face : shbt_pkg::FACE_XNEG;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shbt_pkg::result_t want;
		if (!arst_n) begin
			fail_count <= 0;
			checked_words <= 0;
			expected_hits.delete();
		end else begin
			if (item.valid && item.ready)
				expected_hits.push_back(predict_hit(item.data));
			if (result.valid && result.ready) begin
				checked_words <= checked_words + 1;
				if (expected_hits.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result word %p", $time, result.data);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hits.pop_front();
					if (result.data !== want) begin
						if (fail_count < 10)
							$display("%0t: mismatch hit %0d/%0d dist %0h/%0h face %0d/%0d",
								$time, want.hit_found, result.data.hit_found,
								want.hit_distance, result.data.hit_distance,
								want.hit_face, result.data.hit_face);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending_hits = expected_hits.size();

endmodule

@@ verif/swept_box_hit_test_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for swept_box_hit_test_unit: directed corner cases, then
// random box pairs under several idle/stall phases. Checking is done by
// swept_box_hit_test_unit_chk; depends on shbt_pkg and shbt_if.sv.
module swept_box_hit_test_unit_tb;

	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 0;
	logic arst_n = 0;
	int fail_count, pending_hits, checked_words;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent_items = 0;
	int cycles = 0;

	shbt_item_if   item_ch();
	shbt_result_if result_ch();

	swept_box_hit_test_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	swept_box_hit_test_unit_chk chk (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.pending_hits(pending_hits),
		.checked_words(checked_words)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 0;
		else
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("swept_box_hit_test_unit_tb: errors");
			$finish;
		end
	end

	function automatic longint spread(int r);
		return longint'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic shbt_pkg::item_t box_pair(longint px, longint py, longint pw, longint ph,
			longint dx, longint dy, longint step, longint tx, longint ty,
			longint tw, longint th, bit en);
		shbt_pkg::item_t it;
		it.mover_x = px[shbt_pkg::CW-1:0];
		it.mover_y = py[shbt_pkg::CW-1:0];
		it.mover_width = pw[shbt_pkg::SZ_W-1:0];
		it.mover_height = ph[shbt_pkg::SZ_W-1:0];
		it.dir_x = dx[shbt_pkg::CW-1:0];
		it.dir_y = dy[shbt_pkg::CW-1:0];
		it.step_limit = step[shbt_pkg::SZ_W-1:0];
		it.target_x = tx[shbt_pkg::CW-1:0];
		it.target_y = ty[shbt_pkg::CW-1:0];
		it.target_width = tw[shbt_pkg::SZ_W-1:0];
		it.target_height = th[shbt_pkg::SZ_W-1:0];
		it.target_enabled = en;
		return it;
	endfunction

	// mover aimed roughly at the target, with random offsets and sizes
	function automatic shbt_pkg::item_t aimed_pair();
		longint tx, ty, tw, th, pw, ph, px, py, dx, dy, step;
		tx = spread(1 << 24);
		ty = spread(1 << 24);
		tw = $urandom_range(0, 1 << 22);
		th = $urandom_range(0, 1 << 22);
		pw = $urandom_range(0, 1 << 22);
		ph = $urandom_range(0, 1 << 22);
		px = tx + spread(1 << 23);
		py = ty + spread(1 << 23);
		dx = (tx + tw / 2) - (px + pw / 2) + spread(1 << $urandom_range(4, 22));
		dy = (ty + th / 2) - (py + ph / 2) + spread(1 << $urandom_range(4, 22));
		case ($urandom_range(7))
			0: dx = 0;
			1: dy = 0;
			2: begin dx = dx >>> 8; dy = dy >>> 8; end
			default: ;
		endcase
		step = ($urandom_range(15) == 0) ? 64'h7fff_ffff : $urandom_range(0, 1 << 26);
		return box_pair(px, py, pw, ph, dx, dy, step, tx, ty, tw, th,
			$urandom_range(19) != 0);
	endfunction

	function automatic shbt_pkg::item_t noise_pair();
		shbt_pkg::item_t it;
		it = shbt_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		return it;
	endfunction

	task automatic send(shbt_pkg::item_t it);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			item_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
		sent_items++;
	endtask

	localparam longint ONE = 64'h1_0000;
	localparam longint SMAX = 64'h7fff_ffff;
	localparam longint CMIN = -64'sh8000_0000;

	initial begin
		item_ch.valid = 0;
		item_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// hit on each face
		send(box_pair(0, 0, ONE, ONE, ONE, 0, 10 * ONE, 4 * ONE, 0, ONE, ONE, 1));
		send(box_pair(8 * ONE, 0, ONE, ONE, -ONE, 0, 10 * ONE, 4 * ONE, 0, ONE, ONE, 1));
		send(box_pair(0, 0, ONE, ONE, 0, 3 * ONE, 10 * ONE, 0, 4 * ONE, ONE, ONE, 1));
		send(box_pair(0, 8 * ONE, ONE, ONE, 0, -ONE, 10 * ONE, 0, 4 * ONE, ONE, ONE, 1));
		// disabled target, zero direction
		send(box_pair(0, 0, ONE, ONE, ONE, 0, 10 * ONE, 4 * ONE, 0, ONE, ONE, 0));
		send(box_pair(0, 0, ONE, ONE, 0, 0, 10 * ONE, 4 * ONE, 0, ONE, ONE, 1));
		// diagonal into a corner: equal distances, x face first
		send(box_pair(0, 0, ONE, ONE, ONE, ONE, 20 * ONE, 3 * ONE, 3 * ONE, ONE, ONE, 1));
		send(box_pair(8 * ONE, 8 * ONE, ONE, ONE, -ONE, -ONE, 20 * ONE, 3 * ONE, 3 * ONE,
			ONE, ONE, 1));
		// other axis just touching, and just missing
		send(box_pair(0, 2 * ONE, ONE, ONE, ONE, 0, 10 * ONE, 4 * ONE, 0, ONE, 2 * ONE, 1));
		send(box_pair(0, 2 * ONE + 1, ONE, ONE, ONE, 0, 10 * ONE, 4 * ONE, 0, ONE, 2 * ONE, 1));
		send(box_pair(0, -ONE, ONE, ONE, ONE, 0, 10 * ONE, 4 * ONE, 0, ONE, ONE, 1));
		// gap equal to step, and one below
		send(box_pair(0, 0, ONE, ONE, ONE, 0, 3 * ONE, 4 * ONE, 0, ONE, ONE, 1));
		send(box_pair(0, 0, ONE, ONE, ONE, 0, 3 * ONE + 1, 4 * ONE, 0, ONE, ONE, 1));
		// already overlapping, and touching on x
		send(box_pair(0, 0, 2 * ONE, 2 * ONE, ONE, ONE, 10 * ONE, ONE, ONE, ONE, ONE, 1));
		send(box_pair(0, 0, ONE, ONE, ONE, 0, 10 * ONE, ONE, 0, ONE, ONE, 1));
		// extremes of the fields
		send(box_pair(CMIN, CMIN, 0, 0, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 1));
		send(box_pair(SMAX, SMAX, SMAX, SMAX, CMIN, CMIN, SMAX, CMIN, CMIN, 0, 0, 1));
		send(box_pair(CMIN, 0, 0, SMAX, SMAX, 1, SMAX, 0, CMIN, SMAX, SMAX, 1));
		send(box_pair(0, SMAX, SMAX, 0, -1, CMIN, SMAX, CMIN, 0, SMAX, SMAX, 1));
		send(box_pair(0, 0, 0, 0, 1, 1, SMAX, 1, 1, 0, 0, 1));
		send(box_pair(0, 0, 0, 0, CMIN, 0, 0, -ONE, 0, 0, 0, 1));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n * 4 / RANDOM_ITEMS)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			// drain the pipeline once mid-run
			if (n == RANDOM_ITEMS / 3) begin
				item_ch.valid <= 0;
				do @(posedge clk); while (pending_hits != 0);
			end
			send(($urandom_range(4) == 0) ? noise_pair() : aimed_pair());
		end
		item_ch.valid <= 0;
		stall_pct = 0;
		do @(posedge clk); while (pending_hits != 0);
		repeat (120) @(posedge clk);

		$display("sent %0d box pairs (directed faces, ties, touching, extremes, random)",
			sent_items);
		$display("checked %0d result words, %0d mismatches", checked_words, fail_count);
		if (fail_count == 0)
			$display("swept_box_hit_test_unit_tb: clean");
		else
			$display("swept_box_hit_test_unit_tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/shbt_pkg.sv
hdl/shbt_if.sv
hdl/shbt_isqrt.sv
hdl/shbt_div.sv
hdl/shbt_face.sv
hdl/swept_box_hit_test_unit.sv
verif/swept_box_hit_test_unit_chk.sv
verif/swept_box_hit_test_unit_tb.sv
